[hw/rtl/peer_link_setup_fsm_top_defines.svh]
// ---------------------------------------------------------------------------
// Peer link setup FSM assertion macros
// Shared concurrent-assertion shorthands for the link setup block.
// ---------------------------------------------------------------------------
`ifndef PEER_LINK_SETUP_FSM_TOP_DEFINES_SVH
`define PEER_LINK_SETUP_FSM_TOP_DEFINES_SVH

// same-cycle implication
`define PLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/plf_pkg.sv]
// ---------------------------------------------------------------------------
// Peer link setup package
// Status, message and channel codes plus shared types of the link setup block.
// ---------------------------------------------------------------------------
package plf_pkg;

  localparam int TIME_W  = 32;
  localparam int DIGIT_W = 8;
  localparam int REM_STEPS = TIME_W / DIGIT_W;
  localparam int REM_CNT_W = $clog2(REM_STEPS);

  // link status
  localparam logic [3:0] ST_INIT       = 4'd0;
  localparam logic [3:0] ST_CONNECTING = 4'd1;
  localparam logic [3:0] ST_WAIT_NT    = 4'd2;
  localparam logic [3:0] ST_WAIT_NT1   = 4'd3;
  localparam logic [3:0] ST_WAIT_PONG  = 4'd4;
  localparam logic [3:0] ST_WAIT_RNT   = 4'd5;
  localparam logic [3:0] ST_WAIT_ECHO  = 4'd6;
  localparam logic [3:0] ST_WAIT_CONN  = 4'd7;
  localparam logic [3:0] ST_CONNECTED  = 4'd8;
  localparam logic [3:0] ST_DISCONNECT = 4'd9;

  // sent message codes
  localparam logic [3:0] TX_NONE      = 4'd0;
  localparam logic [3:0] TX_PONG      = 4'd1;
  localparam logic [3:0] TX_UDPPING   = 4'd2;
  localparam logic [3:0] TX_PING      = 4'd3;
  localparam logic [3:0] TX_UDPTEST   = 4'd4;
  localparam logic [3:0] TX_REQTEST   = 4'd5;
  localparam logic [3:0] TX_GETNT     = 4'd6;
  localparam logic [3:0] TX_CONNECTED = 4'd7;
  localparam logic [3:0] TX_HB        = 4'd8;
  localparam logic [3:0] TX_DISC      = 4'd9;

  // received message codes
  localparam logic [2:0] RX_PING     = 3'd0;
  localparam logic [2:0] RX_PONG     = 3'd1;
  localparam logic [2:0] RX_UDPPONG  = 3'd2;
  localparam logic [2:0] RX_RESPTEST = 3'd3;
  localparam logic [2:0] RX_RESPCONN = 3'd4;
  localparam logic [2:0] RX_HB       = 3'd5;
  localparam logic [2:0] RX_NETTYPE  = 3'd6;

  // channels
  localparam logic [1:0] CH_DIRECT = 2'd0;
  localparam logic [1:0] CH_RELAY  = 2'd1;
  localparam logic [1:0] CH_PING1  = 2'd2;
  localparam logic [1:0] CH_PING2  = 2'd3;

  // action
  localparam logic ACT_MSG   = 1'b0;
  localparam logic ACT_TIMER = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_REPLY_TO = 2'd0;
  localparam logic [1:0] CFG_DISC_TO  = 2'd1;
  localparam logic [1:0] CFG_HB_PER   = 2'd2;

  typedef struct packed {
    logic              action;
    logic [TIME_W-1:0] now_sec;
    logic [2:0]        rx_cmd;
    logic [15:0]       rx_port;
    logic [31:0]       rx_addr;
    logic              rx_nettype;
  } item_t;

  typedef struct packed {
    logic [3:0]  tx_cmd;
    logic [1:0]  tx_channel;
    logic [15:0] tx_port;
    logic [31:0] tx_addr;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } emit_t;

  function automatic res_t mk_res(logic [3:0] cmd, logic [1:0] ch,
                                  logic [15:0] port, logic [31:0] addr);
    res_t r;
    r.tx_cmd     = cmd;
    r.tx_channel = ch;
    r.tx_port    = port;
    r.tx_addr    = addr;
    return r;
  endfunction

endpackage

[hw/rtl/peer_link_setup_fsm_top.sv]
// ---------------------------------------------------------------------------
// Peer link setup FSM top
// Connection setup sequencer: takes messages and timer polls, emits sends.
// ---------------------------------------------------------------------------
// channel | handshake         | payload
// in      | in_valid/in_stall | action, now_sec, rx_cmd, rx_port, rx_addr, rx_nettype
// out     | out_valid/out_stall | tx_cmd, tx_channel, tx_port, tx_addr, link_status, last
// cfg     | cfg_we            | cfg_index, cfg_wdata
//
// One item at a time. The input transfer registers the item and starts the heartbeat
// remainder unit (one byte per cycle); its done strobe commits the link state and latches
// the results, which are then sent in order, the second only when the item has two.
// in_stall stays high until the last result of the item is transferred.
// Synchronous active-low reset; no clearing pass.
// ---------------------------------------------------------------------------
`include "peer_link_setup_fsm_top_defines.svh"

module peer_link_setup_fsm_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_now_sec,
  input  logic [2:0]  in_rx_cmd,
  input  logic [15:0] in_rx_port,
  input  logic [31:0] in_rx_addr,
  input  logic        in_rx_nettype,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_tx_cmd,
  output logic [1:0]  out_tx_channel,
  output logic [15:0] out_tx_port,
  output logic [31:0] out_tx_addr,
  output logic [3:0]  out_link_status,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import plf_pkg::*;

  localparam logic [1:0] SQ_IDLE  = 2'd0;
  localparam logic [1:0] SQ_CALC  = 2'd1;
  localparam logic [1:0] SQ_SEND0 = 2'd2;
  localparam logic [1:0] SQ_SEND1 = 2'd3;

  logic [1:0]         seq_r, seq_nxt;
  logic               in_xfer, rem_done, rem_zero;
  item_t              item_r;
  emit_t              emit;
  res_t               res0_r, res1_r, res_sel;
  logic               two_r;
  logic [3:0]         status;
  logic [TIME_W-1:0]  rem_dividend;
  logic [DIGIT_W-1:0] rem_divisor;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (seq_r != SQ_IDLE);

  plf_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  plf_ctl u_ctl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .item         (item_r),
    .now_in       (in_now_sec),
    .commit       (rem_done),
    .rem_zero     (rem_zero),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .emit         (emit),
    .status       (status)
  );

  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SQ_IDLE:  if (in_xfer) seq_nxt = SQ_CALC;
      SQ_CALC:  if (rem_done) seq_nxt = SQ_SEND0;
      SQ_SEND0: if (!out_stall) seq_nxt = two_r ? SQ_SEND1 : SQ_IDLE;
      SQ_SEND1: if (!out_stall) seq_nxt = SQ_IDLE;
      default:  seq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.action     <= in_action;
      item_r.now_sec    <= in_now_sec;
      item_r.rx_cmd     <= in_rx_cmd;
      item_r.rx_port    <= in_rx_port;
      item_r.rx_addr    <= in_rx_addr;
      item_r.rx_nettype <= in_rx_nettype;
    end
    if (seq_r == SQ_CALC && rem_done) begin
      res0_r <= emit.r0;
      res1_r <= emit.r1;
      two_r  <= (emit.cnt == 2'd2);
    end
  end

  assign res_sel         = (seq_r == SQ_SEND1) ? res1_r : res0_r;
  assign out_valid       = (seq_r == SQ_SEND0) || (seq_r == SQ_SEND1);
  assign out_tx_cmd      = res_sel.tx_cmd;
  assign out_tx_channel  = res_sel.tx_channel;
  assign out_tx_port     = res_sel.tx_port;
  assign out_tx_addr     = res_sel.tx_addr;
  assign out_link_status = status;
  assign out_last        = (seq_r == SQ_SEND1) || !two_r;

  `PLF_ASSERT_NOW(a_result_blocks_input, out_valid, in_stall, "input open while result pending")
  `PLF_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall && !out_valid, "no busy after transfer")
  `PLF_ASSERT_NEXT(a_last_then_idle, out_valid && !out_stall && out_last, !out_valid && !in_stall, "not idle after last")
  `PLF_ASSERT_NEXT(a_first_then_second, out_valid && !out_stall && !out_last, out_valid && out_last, "second result missing")

endmodule

[hw/rtl/plf_rem.sv]
// ---------------------------------------------------------------------------
// Peer link setup remainder unit
// Iterative remainder of a 32-bit value by an 8-bit divisor, one byte a cycle.
// ---------------------------------------------------------------------------
module plf_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [plf_pkg::TIME_W-1:0] dividend,
  input  logic [plf_pkg::DIGIT_W-1:0] divisor,
  output logic                      done,
  output logic                      rem_zero
);
  import plf_pkg::*;

  logic                 busy_r;
  logic [REM_CNT_W-1:0] cnt_r;
  logic                 done_r;
  logic [TIME_W-1:0]    q_r;
  logic [DIGIT_W-1:0]   div_r;
  logic [DIGIT_W-1:0]   rem_r;
  logic [DIGIT_W-1:0]   rem_nxt;

  always_comb begin
    logic [DIGIT_W:0] t;
    rem_nxt = rem_r;
    for (int i = 0; i < DIGIT_W; i++) begin
      t = {rem_nxt, q_r[TIME_W-1-i]};
      if (t >= {1'b0, div_r}) begin
        rem_nxt = DIGIT_W'(t - {1'b0, div_r});
      end else begin
        rem_nxt = t[DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == REM_CNT_W'(REM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= q_r << DIGIT_W;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

[hw/rtl/plf_ctl.sv]
// ---------------------------------------------------------------------------
// Peer link setup control
// Link state, timestamps, addresses and config; decides status and sends.
// ---------------------------------------------------------------------------
module plf_ctl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [7:0]                  cfg_wdata,
  input  plf_pkg::item_t              item,
  input  logic [plf_pkg::TIME_W-1:0]  now_in,
  input  logic                        commit,
  input  logic                        rem_zero,
  output logic [plf_pkg::TIME_W-1:0]  rem_dividend,
  output logic [plf_pkg::DIGIT_W-1:0] rem_divisor,
  output plf_pkg::emit_t              emit,
  output logic [3:0]                  status
);
  import plf_pkg::*;

  logic [7:0]        reply_to_r, disc_to_r, hb_per_r;
  logic [3:0]        st_r, st_nxt;
  logic [TIME_W-1:0] st_stamp_r, st_stamp_nxt;
  logic [TIME_W-1:0] hb_stamp_r, hb_stamp_nxt;
  logic [15:0]       own_port_r, own_port_nxt;
  logic [31:0]       own_addr_r, own_addr_nxt;
  logic              own_nat_r, own_nat_nxt;
  logic              peer_nat_r, peer_nat_nxt;
  logic [15:0]       peer_port_r, peer_port_nxt;
  logic [31:0]       peer_addr_r, peer_addr_nxt;
  logic [TIME_W-1:0] el, hb;
  logic              disc_ok, reply_ok, hb_late;

  assign rem_dividend = now_in - hb_stamp_r;
  assign rem_divisor  = (hb_per_r == '0) ? DIGIT_W'(1) : hb_per_r;

  assign el       = item.now_sec - st_stamp_r;
  assign hb       = item.now_sec - hb_stamp_r;
  assign disc_ok  = el <= {24'd0, disc_to_r};
  assign reply_ok = el <= {24'd0, reply_to_r};
  assign hb_late  = hb > {24'd0, reply_to_r};

  always_comb begin
    st_nxt        = st_r;
    st_stamp_nxt  = st_stamp_r;
    hb_stamp_nxt  = hb_stamp_r;
    own_port_nxt  = own_port_r;
    own_addr_nxt  = own_addr_r;
    own_nat_nxt   = own_nat_r;
    peer_nat_nxt  = peer_nat_r;
    peer_port_nxt = peer_port_r;
    peer_addr_nxt = peer_addr_r;
    emit          = '0;
    if (item.action == ACT_MSG) begin
      if (item.rx_cmd == RX_PING) begin
        emit.cnt = 2'd1;
        emit.r0  = mk_res(TX_PONG, CH_DIRECT, 16'd0, 32'd0);
      end else begin
        unique case (st_r)
          ST_WAIT_NT: begin
            if (item.rx_cmd == RX_UDPPONG) begin
              own_addr_nxt = item.rx_addr;
              own_port_nxt = item.rx_port;
              st_nxt       = ST_WAIT_NT1;
              st_stamp_nxt = item.now_sec;
              emit.cnt     = 2'd1;
              emit.r0      = mk_res(TX_UDPPING, CH_PING2, 16'd0, 32'd0);
            end
          end
          ST_WAIT_NT1: begin
            if (item.rx_cmd == RX_UDPPONG) begin
              own_addr_nxt = item.rx_addr;
              own_nat_nxt  = (own_port_r != item.rx_port);
              st_nxt       = ST_WAIT_PONG;
              st_stamp_nxt = item.now_sec;
              emit.cnt     = 2'd1;
              emit.r0      = mk_res(TX_PING, CH_RELAY, 16'd0, 32'd0);
            end
          end
          ST_WAIT_PONG: begin
            if (item.rx_cmd == RX_PONG) begin
              st_nxt       = ST_WAIT_RNT;
              st_stamp_nxt = item.now_sec;
              emit.cnt     = 2'd1;
              emit.r0      = mk_res(TX_GETNT, CH_RELAY, own_port_r, own_addr_r);
            end
          end
          ST_WAIT_RNT: begin
            if (item.rx_cmd == RX_NETTYPE) begin
              peer_nat_nxt  = item.rx_nettype;
              peer_port_nxt = item.rx_port;
              peer_addr_nxt = item.rx_addr;
              if (!own_nat_r && !item.rx_nettype) begin
                st_nxt       = ST_WAIT_ECHO;
                st_stamp_nxt = item.now_sec;
                emit.cnt     = 2'd2;
                emit.r0      = mk_res(TX_UDPTEST, CH_DIRECT, 16'd0, 32'd0);
                emit.r1      = mk_res(TX_REQTEST, CH_RELAY, own_port_r, 32'd0);
              end
            end
          end
          ST_WAIT_ECHO: begin
            if (item.rx_cmd == RX_RESPTEST) begin
              st_nxt       = ST_WAIT_CONN;
              st_stamp_nxt = item.now_sec;
              emit.cnt     = 2'd1;
              emit.r0      = mk_res(TX_CONNECTED, CH_RELAY, own_port_r, 32'd0);
            end
          end
          ST_WAIT_CONN: begin
            if (item.rx_cmd == RX_RESPCONN) begin
              hb_stamp_nxt = item.now_sec;
              st_nxt       = ST_CONNECTED;
              st_stamp_nxt = item.now_sec;
            end
          end
          ST_CONNECTED: begin
            if (item.rx_cmd == RX_HB) begin
              hb_stamp_nxt = item.now_sec;
            end
          end
          default: begin
          end
        endcase
      end
    end else begin
      unique case (st_r)
        ST_INIT, ST_DISCONNECT: begin
          st_nxt       = ST_CONNECTING;
          st_stamp_nxt = item.now_sec;
        end
        ST_CONNECTING: begin
          st_nxt       = ST_WAIT_NT;
          st_stamp_nxt = item.now_sec;
          emit.cnt     = 2'd1;
          emit.r0      = mk_res(TX_UDPPING, CH_PING1, 16'd0, 32'd0);
        end
        ST_WAIT_NT, ST_WAIT_NT1: begin
          if (disc_ok) begin
            emit.cnt = 2'd1;
            emit.r0  = (st_r == ST_WAIT_NT) ?
                       mk_res(TX_PING, CH_RELAY, 16'd0, 32'd0) :
                       mk_res(TX_UDPPING, CH_PING2, 16'd0, 32'd0);
          end else begin
            st_nxt       = ST_DISCONNECT;
            st_stamp_nxt = item.now_sec;
          end
        end
        ST_WAIT_PONG, ST_WAIT_RNT, ST_WAIT_ECHO, ST_WAIT_CONN: begin
          if (reply_ok) begin
            emit.cnt = 2'd1;
            unique case (st_r)
              ST_WAIT_PONG: emit.r0 = mk_res(TX_PING, CH_RELAY, 16'd0, 32'd0);
              ST_WAIT_RNT:  emit.r0 = mk_res(TX_GETNT, CH_RELAY, own_port_r, own_addr_r);
              ST_WAIT_ECHO: begin
                emit.cnt = 2'd2;
                emit.r0  = mk_res(TX_UDPTEST, CH_DIRECT, 16'd0, 32'd0);
                emit.r1  = mk_res(TX_REQTEST, CH_RELAY, own_port_r, 32'd0);
              end
              default:      emit.r0 = mk_res(TX_CONNECTED, CH_RELAY, own_port_r, 32'd0);
            endcase
          end else begin
            st_nxt       = ST_DISCONNECT;
            st_stamp_nxt = item.now_sec;
          end
        end
        ST_CONNECTED: begin
          if (hb_late) begin
            st_nxt       = ST_DISCONNECT;
            st_stamp_nxt = item.now_sec;
          end
          priority if (rem_zero && hb_late) begin
            emit.cnt = 2'd2;
            emit.r0  = mk_res(TX_HB, CH_DIRECT, own_port_r, 32'd0);
            emit.r1  = mk_res(TX_DISC, CH_RELAY, 16'd0, 32'd0);
          end else if (rem_zero) begin
            emit.cnt = 2'd1;
            emit.r0  = mk_res(TX_HB, CH_DIRECT, own_port_r, 32'd0);
          end else if (hb_late) begin
            emit.cnt = 2'd1;
            emit.r0  = mk_res(TX_DISC, CH_RELAY, 16'd0, 32'd0);
          end else begin
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_to_r <= 8'd5;
      disc_to_r  <= 8'd5;
      hb_per_r   <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPLY_TO: reply_to_r <= cfg_wdata;
        CFG_DISC_TO:  disc_to_r  <= cfg_wdata;
        CFG_HB_PER:   hb_per_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_INIT;
      st_stamp_r  <= '0;
      hb_stamp_r  <= '0;
      own_port_r  <= '0;
      own_addr_r  <= '0;
      own_nat_r   <= 1'b0;
      peer_nat_r  <= 1'b0;
      peer_port_r <= '0;
      peer_addr_r <= '0;
    end else if (commit) begin
      st_r        <= st_nxt;
      st_stamp_r  <= st_stamp_nxt;
      hb_stamp_r  <= hb_stamp_nxt;
      own_port_r  <= own_port_nxt;
      own_addr_r  <= own_addr_nxt;
      own_nat_r   <= own_nat_nxt;
      peer_nat_r  <= peer_nat_nxt;
      peer_port_r <= peer_port_nxt;
      peer_addr_r <= peer_addr_nxt;
    end
  end

  assign status = st_r;

endmodule

[sim/plf_link_checker.sv]
// ----------------------------------------------------------------------------
// Peer link setup checker
// Watches the input, result and register ports of the link setup block, keeps
// its own copy of the link state and timers, predicts the sends of each
// transfer and compares every result transfer field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plf_link_checker
  import plf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_now_sec,
  input  logic [2:0]  in_rx_cmd,
  input  logic [15:0] in_rx_port,
  input  logic [31:0] in_rx_addr,
  input  logic        in_rx_nettype,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_tx_cmd,
  input  logic [1:0]  out_tx_channel,
  input  logic [15:0] out_tx_port,
  input  logic [31:0] out_tx_addr,
  input  logic [3:0]  out_link_status,
  input  logic        out_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output int          mismatch_count,
  output int          pending_sends
);

  typedef struct packed {
    logic [3:0]  cmd;
    logic [1:0]  ch;
    logic [15:0] port;
    logic [31:0] addr;
    logic [3:0]  status;
    logic        last;
  } link_send_t;

  link_send_t  expected_sends[$];
  link_send_t  want;
  link_send_t  got;
  int          mismatches;

  logic [7:0]  reply_to;
  logic [7:0]  disc_to;
  logic [7:0]  hb_per;

  logic [3:0]  link_state;
  logic [31:0] state_stamp;
  logic [31:0] hb_stamp;
  logic [15:0] own_port;
  logic [31:0] own_addr;
  logic        own_nat;
  logic        peer_nat;
  logic [15:0] peer_port;
  logic [31:0] peer_addr;

  res_t        step_sends[2];
  int          step_count;

  function automatic void add_send(logic [3:0] cmd, logic [1:0] ch, logic [15:0] port,
                                   logic [31:0] addr);
    if (step_count < 2) begin
      step_sends[step_count].tx_cmd     = cmd;
      step_sends[step_count].tx_channel = ch;
      step_sends[step_count].tx_port    = port;
      step_sends[step_count].tx_addr    = addr;
      step_count++;
    end
  endfunction

  function automatic void move_to(logic [3:0] s, logic [31:0] now);
    link_state  = s;
    state_stamp = now;
  endfunction

  function automatic void predict_message(logic [31:0] now, logic [2:0] cmd,
                                          logic [15:0] port, logic [31:0] addr,
                                          logic nt);
    if (cmd == RX_PING)
      add_send(TX_PONG, CH_DIRECT, 16'd0, 32'd0);
    case (link_state)
      ST_WAIT_NT: if (cmd == RX_UDPPONG) begin
        own_addr = addr;
        own_port = port;
        move_to(ST_WAIT_NT1, now);
        add_send(TX_UDPPING, CH_PING2, 16'd0, 32'd0);
      end
      ST_WAIT_NT1: if (cmd == RX_UDPPONG) begin
        own_addr = addr;
        own_nat  = (own_port != port);
        move_to(ST_WAIT_PONG, now);
        add_send(TX_PING, CH_RELAY, 16'd0, 32'd0);
      end
      ST_WAIT_PONG: if (cmd == RX_PONG) begin
        move_to(ST_WAIT_RNT, now);
        add_send(TX_GETNT, CH_RELAY, own_port, own_addr);
      end
      ST_WAIT_RNT: if (cmd == RX_NETTYPE) begin
        peer_nat  = nt;
        peer_port = port;
        peer_addr = addr;
        // hole punch only when both ends are cone NATs
        if (!own_nat && !peer_nat) begin
          move_to(ST_WAIT_ECHO, now);
          add_send(TX_UDPTEST, CH_DIRECT, 16'd0, 32'd0);
          add_send(TX_REQTEST, CH_RELAY, own_port, 32'd0);
        end
      end
      ST_WAIT_ECHO: if (cmd == RX_RESPTEST) begin
        move_to(ST_WAIT_CONN, now);
        add_send(TX_CONNECTED, CH_RELAY, own_port, 32'd0);
      end
      ST_WAIT_CONN: if (cmd == RX_RESPCONN) begin
        hb_stamp = now;
        move_to(ST_CONNECTED, now);
      end
      ST_CONNECTED: if (cmd == RX_HB) begin
        hb_stamp = now;
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_poll(logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] since_hb;
    logic [31:0] period;
    elapsed  = now - state_stamp;
    since_hb = now - hb_stamp;
    period   = (hb_per == 8'd0) ? 32'd1 : {24'd0, hb_per};
    case (link_state)
      ST_INIT: move_to(ST_CONNECTING, now);
      ST_CONNECTING: begin
        move_to(ST_WAIT_NT, now);
        add_send(TX_UDPPING, CH_PING1, 16'd0, 32'd0);
      end
      ST_WAIT_NT: begin
        if (elapsed <= {24'd0, disc_to}) add_send(TX_PING, CH_RELAY, 16'd0, 32'd0);
        else move_to(ST_DISCONNECT, now);
      end
      ST_WAIT_NT1: begin
        if (elapsed <= {24'd0, disc_to}) add_send(TX_UDPPING, CH_PING2, 16'd0, 32'd0);
        else move_to(ST_DISCONNECT, now);
      end
      ST_WAIT_PONG: begin
        if (elapsed <= {24'd0, reply_to}) add_send(TX_PING, CH_RELAY, 16'd0, 32'd0);
        else move_to(ST_DISCONNECT, now);
      end
      ST_WAIT_RNT: begin
        if (elapsed <= {24'd0, reply_to}) add_send(TX_GETNT, CH_RELAY, own_port, own_addr);
        else move_to(ST_DISCONNECT, now);
      end
      ST_WAIT_ECHO: begin
        if (elapsed <= {24'd0, reply_to}) begin
          add_send(TX_UDPTEST, CH_DIRECT, 16'd0, 32'd0);
          add_send(TX_REQTEST, CH_RELAY, own_port, 32'd0);
        end else begin
          move_to(ST_DISCONNECT, now);
        end
      end
      ST_WAIT_CONN: begin
        if (elapsed <= {24'd0, reply_to}) add_send(TX_CONNECTED, CH_RELAY, own_port, 32'd0);
        else move_to(ST_DISCONNECT, now);
      end
      ST_CONNECTED: begin
        if (since_hb % period == 32'd0)
          add_send(TX_HB, CH_DIRECT, own_port, 32'd0);
        if (since_hb > {24'd0, reply_to}) begin
          move_to(ST_DISCONNECT, now);
          add_send(TX_DISC, CH_RELAY, 16'd0, 32'd0);
        end
      end
      ST_DISCONNECT: move_to(ST_CONNECTING, now);
      default: ;
    endcase
  endfunction

  function automatic void predict_transfer();
    link_send_t s;
    step_count = 0;
    if (in_action == ACT_MSG)
      predict_message(in_now_sec, in_rx_cmd, in_rx_port, in_rx_addr, in_rx_nettype);
    else
      predict_poll(in_now_sec);
    if (step_count == 0)
      add_send(TX_NONE, CH_DIRECT, 16'd0, 32'd0);
    for (int k = 0; k < step_count; k++) begin
      s.cmd    = step_sends[k].tx_cmd;
      s.ch     = step_sends[k].tx_channel;
      s.port   = step_sends[k].tx_port;
      s.addr   = step_sends[k].tx_addr;
      s.status = link_state;
      s.last   = (k == step_count - 1);
      expected_sends.push_back(s);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reply_to    = 8'd5;
      disc_to     = 8'd5;
      hb_per      = 8'd1;
      link_state  = ST_INIT;
      state_stamp = '0;
      hb_stamp    = '0;
      own_port    = '0;
      own_addr    = '0;
      own_nat     = 1'b0;
      peer_nat    = 1'b0;
      peer_port   = '0;
      peer_addr   = '0;
      mismatches  = 0;
      expected_sends.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REPLY_TO: reply_to = cfg_wdata;
          CFG_DISC_TO:  disc_to  = cfg_wdata;
          CFG_HB_PER:   hb_per   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_transfer();
      if (out_valid && !out_stall) begin
        got = '{out_tx_cmd, out_tx_channel, out_tx_port, out_tx_addr, out_link_status,
                out_last};
        if (expected_sends.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result transfer with nothing expected: cmd %0d ch %0d status %0d",
                     $realtime, got.cmd, got.ch, got.status);
        end else begin
          want = expected_sends.pop_front();
          if (want != got) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected cmd %0d ch %0d port %h addr %h status %0d last %0d",
                       want.cmd, want.ch, want.port, want.addr, want.status, want.last);
              $display("  actual   cmd %0d ch %0d port %h addr %h status %0d last %0d",
                       got.cmd, got.ch, got.port, got.addr, got.status, got.last);
            end
          end
        end
      end
    end
    mismatch_count <= mismatches;
    pending_sends  <= expected_sends.size();
  end

endmodule

[sim/tb_peer_link_setup_fsm_top.sv]
// ----------------------------------------------------------------------------
// Peer link setup testbench
// Drives messages and timer polls into the link setup block: a directed walk
// through both NAT outcomes, heartbeat and timeouts, then random sessions
// steered by the reported link status, under several register settings and
// random idle cycles on both sides. The checker reports the failures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peer_link_setup_fsm_top;
  import plf_pkg::*;

  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [2:0] RX_OTHER       = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [31:0] in_now_sec;
  logic [2:0]  in_rx_cmd;
  logic [15:0] in_rx_port;
  logic [31:0] in_rx_addr;
  logic        in_rx_nettype;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_tx_cmd;
  logic [1:0]  out_tx_channel;
  logic [15:0] out_tx_port;
  logic [31:0] out_tx_addr;
  logic [3:0]  out_link_status;
  logic        out_last;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  int          mismatch_total;
  int          sends_pending;
  logic        gaps_on = 1'b1;
  logic [3:0]  seen_status = ST_INIT;
  logic [31:0] clock_sec;
  logic [15:0] own_port_guess = '0;

  peer_link_setup_fsm_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_now_sec     (in_now_sec),
    .in_rx_cmd      (in_rx_cmd),
    .in_rx_port     (in_rx_port),
    .in_rx_addr     (in_rx_addr),
    .in_rx_nettype  (in_rx_nettype),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_cmd     (out_tx_cmd),
    .out_tx_channel (out_tx_channel),
    .out_tx_port    (out_tx_port),
    .out_tx_addr    (out_tx_addr),
    .out_link_status(out_link_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  plf_link_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_now_sec     (in_now_sec),
    .in_rx_cmd      (in_rx_cmd),
    .in_rx_port     (in_rx_port),
    .in_rx_addr     (in_rx_addr),
    .in_rx_nettype  (in_rx_nettype),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_tx_cmd     (out_tx_cmd),
    .out_tx_channel (out_tx_channel),
    .out_tx_port    (out_tx_port),
    .out_tx_addr    (out_tx_addr),
    .out_link_status(out_link_status),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_total),
    .pending_sends  (sends_pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 13);
  end

  // one item in flight: wait for its last result before the next transfer
  task automatic send_item(input logic act, input logic [31:0] now, input logic [2:0] cmd,
                           input logic [15:0] port, input logic [31:0] addr,
                           input logic nt);
    while (gaps_on && $urandom_range(99) < 13) @(posedge clk);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_now_sec    <= now;
    in_rx_cmd     <= cmd;
    in_rx_port    <= port;
    in_rx_addr    <= addr;
    in_rx_nettype <= nt;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    do @(posedge clk); while (!(out_valid && !out_stall && out_last));
    seen_status = out_link_status;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sends_pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_timing(input logic [7:0] reply, input logic [7:0] disc,
                            input logic [7:0] per);
    wait_drained();
    write_reg(CFG_REPLY_TO, reply);
    write_reg(CFG_DISC_TO, disc);
    write_reg(CFG_HB_PER, per);
  endtask

  task automatic poll(input logic [31:0] now);
    send_item(ACT_TIMER, now, 3'($urandom_range(7)), 16'($urandom), $urandom,
              1'($urandom_range(1)));
  endtask

  task automatic message(input logic [31:0] now, input logic [2:0] cmd,
                         input logic [15:0] port, input logic [31:0] addr, input logic nt);
    send_item(ACT_MSG, now, cmd, port, addr, nt);
  endtask

  task automatic run_directed();
    set_timing(8'd3, 8'd5, 8'd0);
    write_reg(CFG_UNUSED_IDX, 8'hFF);
    message(32'd0, RX_PING, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    message(32'd0, RX_OTHER, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    poll(32'd100);
    poll(32'd100);
    poll(32'd101);
    message(32'd101, RX_UDPPONG, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    message(32'd101, RX_UDPPONG, 16'h1234, 32'd0, 1'b0);
    message(32'd102, RX_PONG, 16'd0, 32'd0, 1'b0);
    // symmetric own NAT: peer type is stored, nothing sent
    message(32'd102, RX_NETTYPE, 16'h00FF, 32'h0000_FFFF, 1'b0);
    poll(32'd110);
    poll(32'd110);
    poll(32'd111);
    message(32'd111, RX_UDPPONG, 16'd0, 32'hA5A5_A5A5, 1'b0);
    poll(32'd112);
    message(32'd112, RX_UDPPONG, 16'd0, 32'h5A5A_5A5A, 1'b1);
    message(32'd112, RX_PONG, 16'd0, 32'd0, 1'b0);
    message(32'd112, RX_NETTYPE, 16'h0F0F, 32'h0F0F_0F0F, 1'b1);
    message(32'd113, RX_NETTYPE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    poll(32'd113);
    message(32'd114, RX_RESPTEST, 16'd0, 32'd0, 1'b0);
    poll(32'd114);
    message(32'd200, RX_RESPCONN, 16'd0, 32'd0, 1'b0);
    message(32'd201, RX_HB, 16'd0, 32'd0, 1'b0);
    poll(32'd201);
    poll(32'd205);
    poll(32'd206);
    poll(32'd207);
    // clock going backwards reads as a long elapsed time
    poll(32'd3);
  endtask

  task automatic random_step();
    int          pick;
    logic        act;
    logic [2:0]  cmd;
    logic [15:0] port;
    logic [31:0] addr;
    logic        nt;
    pick = $urandom_range(99);
    act  = ACT_MSG;
    cmd  = 3'($urandom_range(7));
    port = 16'($urandom);
    addr = $urandom;
    nt   = 1'($urandom_range(1));
    clock_sec = clock_sec + $urandom_range(1);
    if ($urandom_range(99) == 0)
      clock_sec = $urandom;
    if (pick < 10) begin
      act = 1'($urandom_range(1));
    end else if (pick < 16) begin
      cmd = RX_PING;
    end else begin
      case (seen_status)
        ST_WAIT_NT: begin
          if (pick < 35) act = ACT_TIMER;
          else begin
            cmd = RX_UDPPONG;
            own_port_guess = port;
          end
        end
        ST_WAIT_NT1: begin
          if (pick < 35) act = ACT_TIMER;
          else begin
            cmd = RX_UDPPONG;
            if ($urandom_range(3) != 0) port = own_port_guess;
          end
        end
        ST_WAIT_PONG: begin
          if (pick < 35) act = ACT_TIMER;
          else cmd = RX_PONG;
        end
        ST_WAIT_RNT: begin
          if (pick < 35) act = ACT_TIMER;
          else begin
            cmd = RX_NETTYPE;
            nt  = ($urandom_range(3) == 0);
          end
        end
        ST_WAIT_ECHO: begin
          if (pick < 35) act = ACT_TIMER;
          else cmd = RX_RESPTEST;
        end
        ST_WAIT_CONN: begin
          if (pick < 35) act = ACT_TIMER;
          else cmd = RX_RESPCONN;
        end
        ST_CONNECTED: begin
          if (pick < 50) cmd = RX_HB;
          else begin
            act = ACT_TIMER;
            clock_sec = clock_sec + $urandom_range(2);
            if (pick > 95) clock_sec = clock_sec + $urandom_range(600);
          end
        end
        default: act = ACT_TIMER;
      endcase
    end
    send_item(act, clock_sec, cmd, port, addr, nt);
  endtask

  task automatic run_phase(input int count, input logic with_gaps);
    gaps_on = with_gaps;
    repeat (count) random_step();
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_action     <= ACT_MSG;
    in_now_sec    <= '0;
    in_rx_cmd     <= RX_PING;
    in_rx_port    <= '0;
    in_rx_addr    <= '0;
    in_rx_nettype <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_REPLY_TO;
    cfg_wdata     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();

    clock_sec = 32'hFFFF_FFF0;
    set_timing(8'd5, 8'd5, 8'd1);
    run_phase(240, 1'b1);
    set_timing(8'd1, 8'd1, 8'd2);
    run_phase(240, 1'b1);
    set_timing(8'd255, 8'd255, 8'd255);
    run_phase(240, 1'b0);
    set_timing(8'd0, 8'd0, 8'd0);
    run_phase(120, 1'b1);
    set_timing(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    run_phase(120, 1'b1);
    set_timing(8'd2, 8'd3, 8'd3);
    run_phase(240, 1'b1);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
